@@ hw/rtl/fpds_pkg.sv @@
// fpds_pkg: shared widths, register indexes and bundle types for the
// five-point diffusion stencil core and its arithmetic pipeline
// no dependencies
`default_nettype none

package fpds_pkg;

  localparam int DATA_W    = 32;
  localparam int SIDE_W    = 11;
  localparam int COEFF_W   = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_COEFF = 1'd1;

  localparam logic [SIDE_W-1:0]  GRID_SIDE_RST = 11'd22;
  localparam logic [COEFF_W-1:0] COEFF_RST     = 16'd3277;

  // stencil operands of one cell
  typedef struct packed {
    logic signed [DATA_W-1:0] ctr;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] dn;
    logic signed [DATA_W-1:0] lf;
    logic signed [DATA_W-1:0] rt;
  } fpds_ops_t;

  // per-request result control
  typedef struct packed {
    logic bnd;   // boundary cell, center passes through
    logic pair;  // last grid row, input sample follows as second result
    logic last;  // input sample ends its row
  } fpds_flags_t;

endpackage

`default_nettype wire

@@ hw/rtl/fpds_math.sv @@
// fpds_math: three-stage stencil arithmetic with valid/ready flow control
// (sum and weight, two multiplies, round and saturate)
// depends on fpds_pkg
`default_nettype none

module fpds_math
  import fpds_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire fpds_ops_t                ops_i,
  input  wire fpds_flags_t              flg_i,
  input  wire logic [COEFF_W-1:0]       coeff_i,
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic signed [DATA_W-1:0] res_o,
  output      logic signed [DATA_W-1:0] pass_o,
  output      fpds_flags_t              flg_o
);

  localparam int SUM_W  = DATA_W + 2;
  localparam int K_W    = COEFF_W + 3;
  localparam int C_W    = COEFF_W + 1;
  localparam int PROD_W = SUM_W + C_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int Q_W    = ACC_W - COEFF_W;

  logic s2_valid_q, s3_valid_q;
  logic s2_free, s3_free;

  logic signed [SUM_W-1:0]  s2_sum_q, sum_d;
  logic signed [K_W-1:0]    s2_k_q, k_d;
  logic signed [C_W-1:0]    s2_c_q;
  logic signed [DATA_W-1:0] s2_ctr_q, s2_x_q;
  fpds_flags_t              s2_flg_q;

  logic signed [PROD_W-1:0] s3_p1_q, s3_p2_q, p1_d, p2_d;
  logic signed [DATA_W-1:0] s3_ctr_q, s3_x_q;
  fpds_flags_t              s3_flg_q;

  logic signed [ACC_W-1:0]  acc;
  logic signed [Q_W-1:0]    q;
  logic signed [DATA_W-1:0] sat;

  assign s3_free    = !s3_valid_q || out_ready_i;
  assign s2_free    = !s2_valid_q || s3_free;
  assign in_ready_o = s2_free;

  // neighbor sum and center weight 1 - 4C
  assign sum_d = SUM_W'(ops_i.up) + SUM_W'(ops_i.dn) + SUM_W'(ops_i.lf) + SUM_W'(ops_i.rt);
  assign k_d   = K_W'(65536) - $signed({1'b0, coeff_i, 2'b00});

  assign p1_d = PROD_W'(s2_k_q) * PROD_W'(s2_ctr_q);
  assign p2_d = PROD_W'(s2_c_q) * PROD_W'(s2_sum_q);

  // round to nearest, ties up, then saturate
  assign acc = ACC_W'(s3_p1_q) + ACC_W'(s3_p2_q) + ACC_W'(32768);
  assign q   = acc[ACC_W-1:COEFF_W];

  always_comb begin
    if (q[Q_W-1:DATA_W-1] == {(Q_W-DATA_W+1){1'b0}} ||
        q[Q_W-1:DATA_W-1] == {(Q_W-DATA_W+1){1'b1}}) begin
      sat = q[DATA_W-1:0];
    end else if (q[Q_W-1]) begin
      sat = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(DATA_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (s2_free) begin
        s2_valid_q <= in_valid_i;
      end
      if (s3_free) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_free && in_valid_i) begin
      s2_sum_q <= sum_d;
      s2_k_q   <= k_d;
      s2_c_q   <= $signed({1'b0, coeff_i});
      s2_ctr_q <= ops_i.ctr;
      s2_x_q   <= ops_i.dn;
      s2_flg_q <= flg_i;
    end
    if (s3_free && s2_valid_q) begin
      s3_p1_q  <= p1_d;
      s3_p2_q  <= p2_d;
      s3_ctr_q <= s2_ctr_q;
      s3_x_q   <= s2_x_q;
      s3_flg_q <= s2_flg_q;
    end
  end

  assign out_valid_o = s3_valid_q;
  assign res_o       = s3_flg_q.bnd ? s3_ctr_q : sat;
  assign pass_o      = s3_x_q;
  assign flg_o       = s3_flg_q;

endmodule

`default_nettype wire

@@ hw/rtl/five_point_diffusion_stencil_core.sv @@
// Five-point diffusion stencil core. A square grid of signed Q16.16 samples
// streams in raster order, one sample per request, and for every interior cell
// the core returns (1-4C)*center + C*(up+down+left+right), rounded to nearest
// (ties up) and saturated to 32 bits; boundary cells pass through unchanged.
// Results lag one grid row: row r comes out while row r+1 streams in, nothing
// comes out during row 0, and each sample of the last row gives two results,
// the cell above it and then the sample itself, the latter flagged frame_last
// on the final cell. One sample is taken every clock unless the output stalls;
// during the last row the single output port limits intake, since each sample
// there gives two results. Operands of an accepted sample are captured at the
// accepting edge, then pass sum, multiply and round to the output register. Two
// line memories (MAX_SIDE entries, registered read) hold the last two rows; the
// row-above memory has two read ports for the center and its right neighbor, the
// left neighbor is the previous center kept in a register. Reads for the next grid
// position are issued ahead every clock, and since the side is at least three they
// never hit the entry written in the same cycle. No clearing pass is needed after
// reset: every entry read for a result was written earlier in the same frame.
// Writing grid_side restarts the frame; configure only while idle.
`default_nettype none

module five_point_diffusion_stencil_core
  import fpds_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration writes
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  // sample requests
  input  wire logic                     in_valid_i,
  output      logic                     in_ready_o,
  input  wire logic signed [DATA_W-1:0] in_value_i,
  // result requests
  output      logic                     out_valid_o,
  input  wire logic                     out_ready_i,
  output      logic signed [DATA_W-1:0] out_value_o,
  output      logic                     frame_last_o
);

  localparam int AW      = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int SW_NEED = $clog2(MAX_SIDE + 1);
  localparam int SW      = (SW_NEED > SIDE_W) ? SW_NEED : SIDE_W;

  // configuration registers
  logic [SIDE_W-1:0]  grid_side_q;
  logic [COEFF_W-1:0] coeff_q;

  // effective side, clamped
  logic [SW-1:0] side_ext, side_used;
  logic [AW-1:0] last_w;

  // raster position of the next sample
  logic [AW-1:0] col_q, col_d, row_q, row_d;
  logic          row_end, grid_end, in_acc, cfg_side_wr;

  // line memories and their registered read data
  logic [DATA_W-1:0] above_mem [MAX_SIDE];
  logic [DATA_W-1:0] twice_mem [MAX_SIDE];
  logic [DATA_W-1:0] ctr_rd_q, rt_rd_q, up_rd_q;
  logic [DATA_W-1:0] lf_q;
  logic [AW-1:0]     rd_addr, rd_addr_nx;

  // operand capture stage
  logic        s1_valid_q, s1_free;
  fpds_ops_t   s1_ops_q;
  fpds_flags_t s1_flg_q;

  // arithmetic pipeline handshake
  logic                     m_ready, m_valid;
  logic signed [DATA_W-1:0] m_res, m_pass;
  fpds_flags_t              m_flg;

  // output register with room for the second result of a last-row sample
  logic                     out_valid_q, out_last_q, out_free;
  logic signed [DATA_W-1:0] out_value_q;
  logic                     pend_q, pend_last_q;
  logic signed [DATA_W-1:0] pend_value_q;

  assign cfg_side_wr = cfg_we_i && (cfg_idx_i == REG_GRID_SIDE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side_q <= GRID_SIDE_RST;
      coeff_q     <= COEFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_GRID_SIDE:  grid_side_q <= cfg_data_i[SIDE_W-1:0];
        REG_DIFF_COEFF: coeff_q     <= cfg_data_i[COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // side below three acts as three, above the memory depth as the depth
  assign side_ext = SW'(grid_side_q);
  always_comb begin
    priority if (side_ext < SW'(3)) begin
      side_used = SW'(3);
    end else if (side_ext > SW'(MAX_SIDE)) begin
      side_used = SW'(MAX_SIDE);
    end else begin
      side_used = side_ext;
    end
  end
  assign last_w = AW'(side_used - SW'(1));

  assign row_end  = (col_q == last_w);
  assign grid_end = (row_q == last_w);
  assign in_acc   = in_valid_i && in_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    priority if (cfg_side_wr) begin
      col_d = '0;
      row_d = '0;
    end else if (in_acc) begin
      if (row_end) begin
        col_d = '0;
        row_d = grid_end ? '0 : row_q + AW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // prefetch for the next position; the written entry is never among these
  assign rd_addr    = col_d;
  assign rd_addr_nx = col_d + AW'(1);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_mem[col_q] <= in_value_i;
      twice_mem[col_q] <= ctr_rd_q;
    end
    ctr_rd_q <= above_mem[rd_addr];
    rt_rd_q  <= above_mem[rd_addr_nx];
    up_rd_q  <= twice_mem[rd_addr];
  end

  // previous center is the left neighbor of the next cell in the row
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      lf_q <= ctr_rd_q;
    end
  end

  // capture operands; row 0 only fills the line memories
  assign s1_free    = !s1_valid_q || m_ready;
  assign in_ready_o = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_acc && (row_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_ops_q.ctr  <= $signed(ctr_rd_q);
      s1_ops_q.up   <= $signed(up_rd_q);
      s1_ops_q.dn   <= in_value_i;
      s1_ops_q.lf   <= $signed(lf_q);
      s1_ops_q.rt   <= $signed(rt_rd_q);
      s1_flg_q.bnd  <= (row_q == AW'(1)) || (col_q == '0) || row_end;
      s1_flg_q.pair <= grid_end;
      s1_flg_q.last <= row_end;
    end
  end

  fpds_math u_math (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_valid_q),
    .in_ready_o  (m_ready),
    .ops_i       (s1_ops_q),
    .flg_i       (s1_flg_q),
    .coeff_i     (coeff_q),
    .out_valid_o (m_valid),
    .out_ready_i (out_free),
    .res_o       (m_res),
    .pass_o      (m_pass),
    .flg_o       (m_flg)
  );

  // output register takes a new request once its last result is leaving
  assign out_free = !out_valid_q || (out_ready_i && !pend_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else if (m_valid && out_free) begin
      out_valid_q <= 1'b1;
      pend_q      <= m_flg.pair;
    end else if (out_valid_q && out_ready_i) begin
      if (pend_q) begin
        pend_q <= 1'b0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_valid && out_free) begin
      out_value_q  <= m_res;
      out_last_q   <= 1'b0;
      pend_value_q <= m_pass;
      pend_last_q  <= m_flg.last;
    end else if (out_valid_q && out_ready_i && pend_q) begin
      out_value_q <= pend_value_q;
      out_last_q  <= pend_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign frame_last_o = out_last_q;

  // a second result is only ever held behind a first one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> out_valid_q)
    else $error("pending second result without a valid output");

  // position stays inside the grid
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= last_w) && (row_q <= last_w))
    else $error("raster position beyond grid side");

  // a sample at the row end wraps the column
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && row_end) |=> (col_q == '0))
    else $error("column did not wrap at row end");

  // frame_last is only set on the second result of a last-row sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_last_q) |-> !pend_q)
    else $error("frame end flag on a first result");

endmodule

`default_nettype wire

@@ tb/fpds_stencil_checker.sv @@
`timescale 1ns / 100ps
// fpds_stencil_checker: watches the config, sample and result ports of the stencil core,
// predicts each cell result in order and counts mismatches
// depends on fpds_pkg
module fpds_stencil_checker
  import fpds_pkg::*;
#(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  input  wire logic                     in_valid_i,
  input  wire logic                     in_ready_i,
  input  wire logic signed [DATA_W-1:0] in_value_i,
  input  wire logic                     out_valid_i,
  input  wire logic                     out_ready_i,
  input  wire logic signed [DATA_W-1:0] out_value_i,
  input  wire logic                     frame_last_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam longint Q_MAX = 64'sh0000_0000_7FFF_FFFF;
  localparam longint Q_MIN = -64'sh0000_0000_8000_0000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              last;
  } cell_result_t;

  logic [SIDE_W-1:0]         grid_side;
  logic [COEFF_W-1:0]        diff_coeff;
  logic signed [DATA_W-1:0]  line_above       [MAX_SIDE];
  logic signed [DATA_W-1:0]  line_twice_above [MAX_SIDE];
  int unsigned               col_pos;
  int unsigned               row_pos;
  cell_result_t              expected_cells [$];
  cell_result_t              want;

  // one explicit diffusion half-step, rounded half up and saturated
  function automatic logic [DATA_W-1:0] diffuse(
    input logic [COEFF_W-1:0]       coeff,
    input logic signed [DATA_W-1:0] ctr,
    input logic signed [DATA_W-1:0] up,
    input logic signed [DATA_W-1:0] dn,
    input logic signed [DATA_W-1:0] lf,
    input logic signed [DATA_W-1:0] rt
  );
    longint c;
    longint acc;
    longint q;
    c   = longint'(coeff);
    acc = (64'sd65536 - 64'sd4 * c) * longint'(ctr)
        + c * (longint'(up) + longint'(dn) + longint'(lf) + longint'(rt));
    q   = (acc + 64'sd32768) >>> 16;
    if (q > Q_MAX) q = Q_MAX;
    if (q < Q_MIN) q = Q_MIN;
    return q[DATA_W-1:0];
  endfunction

  // take one sample, queue the results it releases, shift the line stores
  task automatic advance_grid(input logic signed [DATA_W-1:0] x);
    int unsigned        s;
    int unsigned        last;
    int unsigned        col;
    int unsigned        row;
    logic               row_end;
    logic               grid_end;
    logic [DATA_W-1:0]  res;
    s = 32'(grid_side);
    if (s < 3) s = 3;
    if (s > MAX_SIDE) s = MAX_SIDE;
    last = s - 1;
    col  = (col_pos > last) ? last : col_pos;
    row  = (row_pos > last) ? last : row_pos;
    row_end  = (col == last);
    grid_end = (row == last);
    if (row >= 1) begin
      if (row == 1 || col == 0 || row_end) begin
        res = line_above[col];
      end else begin
        res = diffuse(diff_coeff, line_above[col], line_twice_above[col], x,
                      line_twice_above[col-1], line_above[col+1]);
      end
      expected_cells.push_back('{value: res, last: 1'b0});
      if (grid_end) expected_cells.push_back('{value: x, last: row_end});
    end
    line_twice_above[col] = line_above[col];
    line_above[col]       = x;
    if (row_end) begin
      col_pos = 0;
      row_pos = grid_end ? 0 : row + 1;
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_side  = GRID_SIDE_RST;
      diff_coeff = COEFF_RST;
      col_pos    = 0;
      row_pos    = 0;
      for (int k = 0; k < MAX_SIDE; k++) begin
        line_above[k]       = '0;
        line_twice_above[k] = '0;
      end
      expected_cells.delete();
      pending_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_GRID_SIDE) begin
          grid_side = cfg_data_i[SIDE_W-1:0];
          col_pos   = 0;
          row_pos   = 0;
        end else if (cfg_idx_i == REG_DIFF_COEFF) begin
          diff_coeff = cfg_data_i[COEFF_W-1:0];
        end
      end
      if (in_valid_i && in_ready_i) advance_grid(in_value_i);
      if (out_valid_i && out_ready_i) begin
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value %h last %b",
                   $time, out_value_i, frame_last_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          want = expected_cells.pop_front();
          if (out_value_i !== want.value) begin
            $display("%0t: out_value expected %h actual %h",
                     $time, want.value, out_value_i);
            fail_count_o = fail_count_o + 1;
          end
          if (frame_last_i !== want.last) begin
            $display("%0t: frame_last expected %b actual %b",
                     $time, want.last, frame_last_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      pending_o = expected_cells.size();
    end
  end

endmodule

@@ tb/five_point_diffusion_stencil_core_test.sv @@
`timescale 1ns / 100ps
// five_point_diffusion_stencil_core_test: drives grid frames and config writes into the
// stencil core with random idling on both sides; checking lives in fpds_stencil_checker
// depends on fpds_pkg, five_point_diffusion_stencil_core and fpds_stencil_checker
module five_point_diffusion_stencil_core_test;
  import fpds_pkg::*;

  localparam int                MAX_SIDE  = 1024;
  localparam logic [DATA_W-1:0] S_MAX     = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] S_MIN     = 32'h8000_0000;
  localparam int                SETTLE_CYC = 10;   // margin past the pipeline depth
  localparam int                PHASE_CAP  = 150;  // samples per random phase at most

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_idx    = REG_GRID_SIDE;
  logic [CFG_W-1:0]         cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] in_value   = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic                     frame_last;
  int                       fail_count;
  int                       pending_cells;

  bit                       idle_on    = 1'b1;  // random gaps and stalls allowed
  int                       hold_cycles = 0;
  int                       random_cells = 0;

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  five_point_diffusion_stencil_core #(
    .MAX_SIDE(MAX_SIDE)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_value_i  (in_value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_value_o (out_value),
    .frame_last_o(frame_last)
  );

  fpds_stencil_checker #(
    .MAX_SIDE(MAX_SIDE)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_value_i  (in_value),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_value_i (out_value),
    .frame_last_i(frame_last),
    .fail_count_o(fail_count),
    .pending_o   (pending_cells)
  );

  // result side back-pressure: random stall bursts
  always @(negedge clk) begin
    if (idle_on && hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 10) begin
      hold_cycles = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // sample mix: rails, full-range noise and small values near zero
  function automatic logic [DATA_W-1:0] pick_cell();
    logic [DATA_W-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = S_MAX;
      1:       v = S_MIN;
      2, 3:    v = $urandom();
      default: v = $urandom_range(0, 131071) - 32'd65536;
    endcase
    return v;
  endfunction

  // config write, only called while the core is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we   <= 1'b0;
    cfg_data <= CFG_W'($urandom());
  endtask

  // one sample request, with an optional idle burst in front of it
  task automatic send_cell(input logic [DATA_W-1:0] v);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 6);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_value <= $urandom();
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic stream_cells(input int count);
    for (int k = 0; k < count; k++) send_cell(pick_cell());
  endtask

  task automatic send_row3(input logic [DATA_W-1:0] a, b, c);
    send_cell(a);
    send_cell(b);
    send_cell(c);
  endtask

  // drop valid, let every predicted result drain, then cover the pipeline depth
  // since samples of the first row leave nothing in the queue
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending_cells == 0);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // random side and coefficient, whole frames plus maybe a cut-off frame;
  // sometimes the coefficient changes partway through without a restart
  task automatic random_phase();
    int side_data;
    int s;
    int cells;
    int split;
    case ($urandom_range(0, 9))
      0:       side_data = $urandom_range(0, 2);     // clamps up to 3
      1, 2:    side_data = $urandom_range(10, 12);
      default: side_data = $urandom_range(3, 9);
    endcase
    s = side_data;
    if (s < 3) s = 3;
    // bits above the side field are don't-care
    if ($urandom_range(0, 1) == 1) side_data = side_data | ($urandom_range(0, 31) << SIDE_W);
    idle_on = ($urandom_range(0, 3) != 0);
    write_reg(REG_GRID_SIDE, CFG_W'(side_data));
    case ($urandom_range(0, 5))
      0:       write_reg(REG_DIFF_COEFF, 16'd0);
      1:       write_reg(REG_DIFF_COEFF, 16'hFFFF);
      2:       write_reg(REG_DIFF_COEFF, 16'h8000);   // exact half-way roundings
      3:       write_reg(REG_DIFF_COEFF, COEFF_RST);
      default: write_reg(REG_DIFF_COEFF, CFG_W'($urandom_range(0, 65535)));
    endcase
    cells = $urandom_range(1, 3) * s * s;
    if ($urandom_range(0, 3) == 0) cells = cells + $urandom_range(1, s * s - 1);
    if (cells > PHASE_CAP) cells = PHASE_CAP;
    if ($urandom_range(0, 3) == 0) begin
      split = $urandom_range(1, cells - 1);
      stream_cells(split);
      settle();
      write_reg(REG_DIFF_COEFF, CFG_W'($urandom_range(0, 65535)));
      stream_cells(cells - split);
    end else begin
      stream_cells(cells);
    end
    settle();
    random_cells = random_cells + cells;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed: 3x3 grids, side written below the minimum
    write_reg(REG_GRID_SIDE, 16'd0);
    send_row3(S_MAX, 32'h0000_8000, S_MIN);       // reset coefficient
    send_row3(32'h0001_0000, 32'hFFFF_0000, S_MAX);
    send_row3(S_MIN, 32'h0000_0001, 32'hFFFF_FFFF);
    settle();
    // full coefficient, centre at one rail and neighbors at the other
    write_reg(REG_DIFF_COEFF, 16'hFFFF);
    send_row3(32'd0, S_MAX, 32'd0);               // saturates high
    send_row3(S_MAX, S_MIN, S_MAX);
    send_row3(32'd0, S_MAX, S_MIN);
    settle();
    write_reg(REG_GRID_SIDE, 16'hF802);           // upper bits ignored, side 2 acts as 3
    send_row3(32'd0, S_MIN, 32'd0);               // saturates low
    send_row3(S_MIN, S_MAX, S_MIN);
    send_row3(32'd0, S_MIN, S_MAX);
    settle();

    while (random_cells < 120) random_phase();

    // widest grid, side at or past the top clamp: one full row and the start of the next
    idle_on = 1'b1;
    write_reg(REG_GRID_SIDE, CFG_W'($urandom_range(MAX_SIDE, 2047)));
    write_reg(REG_DIFF_COEFF, CFG_W'($urandom_range(0, 65535)));
    stream_cells(MAX_SIDE + 24);
    settle();

    while (random_cells < 240) random_phase();

    // closing stretch at full rate, no gaps and no stalls
    idle_on = 1'b0;
    write_reg(REG_GRID_SIDE, 16'd8);
    write_reg(REG_DIFF_COEFF, CFG_W'($urandom_range(0, 65535)));
    stream_cells(8 * 8);
    settle();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hard stop well past the slowest legal run
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
